>>> sv/dssm_pkg.sv
// Shared types, constants and codes for the dual stack shared memory core.
`default_nettype none

package dssm_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic SEL_LOW  = 1'b0;
    localparam logic SEL_HIGH = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic capture;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_hit;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> sv/dssm_ctrl.sv
// Control state machine: input acceptance, memory read wait and result hold.
`default_nettype none

module dssm_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    input  dssm_pkg::t_dp_sts    i_sts,
    output dssm_pkg::t_dp_cmd    o_cmd
);

    dssm_pkg::t_state r_state;
    dssm_pkg::t_state n_state;
    logic             can_take;
    logic             accept;

    // A new beat may enter when idle, or when the held result leaves this cycle.
    assign can_take = (r_state == dssm_pkg::ST_IDLE) ||
                      ((r_state == dssm_pkg::ST_RESP) && !i_out_stall);
    assign accept   = can_take && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dssm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.pop_hit ? dssm_pkg::ST_READ : dssm_pkg::ST_RESP;
                end
            end
            dssm_pkg::ST_READ: begin
                n_state = dssm_pkg::ST_RESP;
            end
            dssm_pkg::ST_RESP: begin
                if (!i_out_stall) begin
                    if (i_in_valid) begin
                        n_state = i_sts.pop_hit ? dssm_pkg::ST_READ : dssm_pkg::ST_RESP;
                    end else begin
                        n_state = dssm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = dssm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = !can_take;
        o_out_valid   = (r_state == dssm_pkg::ST_RESP);
        o_cmd.accept  = accept;
        o_cmd.capture = (r_state == dssm_pkg::ST_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dssm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_pop_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.pop_hit) |=> (r_state == dssm_pkg::ST_READ))
        else $error("pop with data did not wait for the memory read");

    a_read_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dssm_pkg::ST_READ) |=> (r_state == dssm_pkg::ST_RESP))
        else $error("memory read did not lead to a result");

    a_no_take_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dssm_pkg::ST_READ) |-> o_in_stall)
        else $error("input taken while a read is pending");
`endif

endmodule

`default_nettype wire

>>> sv/dssm_dp.sv
// Datapath: shared word memory, the two occupancy counters and the result register.
`default_nettype none

module dssm_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  dssm_pkg::t_dp_cmd                   i_cmd,
    output dssm_pkg::t_dp_sts                   o_sts,
    input  wire                                 i_command,
    input  wire                                 i_stack_select,
    input  wire  signed [dssm_pkg::DATA_W-1:0]  i_push_value,
    output logic [1:0]                          o_status,
    output logic signed [dssm_pkg::DATA_W-1:0]  o_pop_value,
    output logic [dssm_pkg::COUNT_W-1:0]        o_low_count,
    output logic [dssm_pkg::COUNT_W-1:0]        o_high_count
);

    localparam int CW = dssm_pkg::CNT_W;
    localparam int AW = dssm_pkg::ADDR_W;
    localparam int DW = dssm_pkg::DATA_W;
    localparam int KW = dssm_pkg::COUNT_W;

    logic [DW-1:0]  mem [dssm_pkg::DEPTH];

    logic [CW-1:0]  r_low_cnt;
    logic [CW-1:0]  r_high_cnt;
    logic [CW-1:0]  n_low_cnt;
    logic [CW-1:0]  n_high_cnt;
    logic [DW-1:0]  r_rd_data;
    logic [1:0]     r_status;
    logic [1:0]     n_status;
    logic [DW-1:0]  r_pop_value;

    logic [CW:0]    used;
    logic           full;
    logic           low_empty;
    logic           high_empty;
    logic           is_push;
    logic           do_write;
    logic           pop_hit;
    logic [CW-1:0]  wr_pos;
    logic [CW-1:0]  rd_pos;
    logic [CW+KW-1:0] low_ext;
    logic [CW+KW-1:0] high_ext;

    always_comb begin
        used       = {1'b0, r_low_cnt} + {1'b0, r_high_cnt};
        full       = (used == (CW + 1)'(dssm_pkg::DEPTH));
        low_empty  = (r_low_cnt == '0);
        high_empty = (r_high_cnt == '0);
        is_push    = (i_command == dssm_pkg::CMD_PUSH);
        do_write   = is_push && !full;
        pop_hit    = !is_push &&
                     ((i_stack_select == dssm_pkg::SEL_LOW) ? !low_empty : !high_empty);

        // The high stack sits at the top of the memory and grows downward.
        if (i_stack_select == dssm_pkg::SEL_LOW) begin
            wr_pos = r_low_cnt;
            rd_pos = r_low_cnt - CW'(1);
        end else begin
            wr_pos = CW'(dssm_pkg::DEPTH - 1) - r_high_cnt;
            rd_pos = CW'(dssm_pkg::DEPTH) - r_high_cnt;
        end

        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        if (do_write) begin
            if (i_stack_select == dssm_pkg::SEL_LOW) begin
                n_low_cnt = r_low_cnt + CW'(1);
            end else begin
                n_high_cnt = r_high_cnt + CW'(1);
            end
        end else if (pop_hit) begin
            if (i_stack_select == dssm_pkg::SEL_LOW) begin
                n_low_cnt = r_low_cnt - CW'(1);
            end else begin
                n_high_cnt = r_high_cnt - CW'(1);
            end
        end

        if (is_push) begin
            n_status = full ? dssm_pkg::STAT_OVERFLOW : dssm_pkg::STAT_OK;
        end else begin
            n_status = pop_hit ? dssm_pkg::STAT_OK : dssm_pkg::STAT_UNDERFLOW;
        end
    end

    assign o_sts.pop_hit = pop_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && do_write) begin
            mem[wr_pos[AW-1:0]] <= i_push_value;
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
        end
    end

    // Result payload; a pop with data then takes the word from the read register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= n_status;
            if (is_push) begin
                r_pop_value <= '0;
            end else if (!pop_hit) begin
                r_pop_value <= '1;
            end
        end else if (i_cmd.capture) begin
            r_pop_value <= r_rd_data;
        end
    end

    assign low_ext      = {{KW{1'b0}}, r_low_cnt};
    assign high_ext     = {{KW{1'b0}}, r_high_cnt};
    assign o_status     = r_status;
    assign o_pop_value  = $signed(r_pop_value);
    assign o_low_count  = low_ext[KW-1:0];
    assign o_high_count = high_ext[KW-1:0];

`ifndef SYNTHESIS
    a_never_overfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (CW + 1)'(dssm_pkg::DEPTH))
        else $error("stacks hold more entries than the memory has");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && do_write) |=> (used == $past(used) + (CW + 1)'(1)))
        else $error("accepted push did not add one entry");
`endif

endmodule

`default_nettype wire

>>> sv/dual_stack_shared_memory_core.sv
// Two stacks in one memory: the low stack grows up from entry 0, the high one
// down from the top entry.
//
// Input channel: i_in_valid / o_in_stall carry one command beat (push or pop on
// the stack named by i_stack_select, with i_push_value for a push). A beat is
// taken on a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result beat per command:
// status, popped word (all ones on underflow, zero for a push) and both counts.
// A push or an underflowing pop has its result registered when it is taken; a
// pop that returns data waits first for the registered read of the shared
// memory port.
// Throughput: one beat per cycle for pushes and failed pops while the receiver
// does not stall; no beat is taken while a pop's memory read is pending. The
// next beat is taken in the same cycle that the held result is taken.
// While the receiver stalls, the result stays in the output register and no
// new command is taken. Synchronous reset empties both stacks and drops any
// pending result; memory contents are not cleared, and only written entries reach a popped result.
`default_nettype none

module dual_stack_shared_memory_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_command,
    input  wire                                 i_stack_select,
    input  wire  signed [dssm_pkg::DATA_W-1:0]  i_push_value,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [dssm_pkg::DATA_W-1:0]  o_pop_value,
    output logic [dssm_pkg::COUNT_W-1:0]        o_low_count,
    output logic [dssm_pkg::COUNT_W-1:0]        o_high_count
);

    dssm_pkg::t_dp_cmd cmd;
    dssm_pkg::t_dp_sts sts;

    dssm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dssm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_command      (i_command),
        .i_stack_select (i_stack_select),
        .i_push_value   (i_push_value),
        .o_status       (o_status),
        .o_pop_value    (o_pop_value),
        .o_low_count    (o_low_count),
        .o_high_count   (o_high_count)
    );

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the dual stack shared memory core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = dssm_pkg::COUNT_W;

    typedef struct packed {
        dssm_pkg::t_status                 status;
        logic [dssm_pkg::DATA_W-1:0]       pop_value;
        logic [dssm_pkg::COUNT_W-1:0]      low_count;
        logic [dssm_pkg::COUNT_W-1:0]      high_count;
    } t_result;

    // One row of directed stimulus; a row may repeat with the value counting up.
    typedef struct packed {
        logic                              cmd;
        logic                              sel;
        logic [dssm_pkg::DATA_W-1:0]       value;
        logic [15:0]                       reps;
        logic                              typed;
        t_result                           res;
    } t_row;

    localparam int NUM_ROWS   = 25;
    localparam int RAND_ITEMS = 830;
    localparam int QUIET_TAIL = 150;
    localparam int LOW_FILL   = 100;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic                                  i_command = dssm_pkg::CMD_PUSH;
    logic                                  i_stack_select = dssm_pkg::SEL_LOW;
    logic signed [dssm_pkg::DATA_W-1:0]    i_push_value = '0;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic [1:0]                            o_status;
    logic signed [dssm_pkg::DATA_W-1:0]    o_pop_value;
    logic [dssm_pkg::COUNT_W-1:0]          o_low_count;
    logic [dssm_pkg::COUNT_W-1:0]          o_high_count;

    // Side-band that travels with the driven beat: a typed-in expectation.
    logic                                  beat_typed = 1'b0;
    t_result                               beat_result = '0;

    logic                                  idle_on = 1'b0;
    logic                                  stall_on = 1'b0;

    logic [dssm_pkg::DATA_W-1:0]           stack_mem [dssm_pkg::DEPTH];
    int                                    low_depth = 0;
    int                                    high_depth = 0;
    t_result                               pending_results [$];

    int                                    fail_count = 0;
    int                                    cmd_count = 0;
    int                                    result_count = 0;
    int                                    overflow_count = 0;
    int                                    underflow_count = 0;
    int                                    data_pop_count = 0;

    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_UNDERFLOW, 32'hFFFFFFFF, 8'd0, 8'd0}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_UNDERFLOW, 32'hFFFFFFFF, 8'd0, 8'd0}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h7FFFFFFF, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd1, 8'd0}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'h80000000, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd1, 8'd1}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h00000000, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd2, 8'd1}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'hFFFFFFFF, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd2, 8'd2}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h80000000, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd3, 8'd2}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'h7FFFFFFF, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd3, 8'd3}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'hFFFFFFFF, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h7FFFFFFF, 8'd3, 8'd2}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'hFFFFFFFF, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h80000000, 8'd2, 8'd2}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'hFFFFFFFF, 8'd2, 8'd1}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h00000000, 8'd1, 8'd1}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h80000000, 8'd1, 8'd0}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_UNDERFLOW, 32'hFFFFFFFF, 8'd1, 8'd0}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h7FFFFFFF, 8'd0, 8'd0}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h55555555, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd1, 8'd0}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'hAAAAAAAA, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h0, 8'd1, 8'd1}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'h55555555, 8'd0, 8'd1}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,        16'd1, 1'b1,
          '{dssm_pkg::STAT_OK, 32'hAAAAAAAA, 8'd0, 8'd0}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h01000000, 16'(LOW_FILL), 1'b0, '0},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'hFE000000,
          16'(dssm_pkg::DEPTH - LOW_FILL), 1'b0, '0},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_LOW,  32'h12345678, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OVERFLOW, 32'h0, CW'(LOW_FILL), CW'(dssm_pkg::DEPTH - LOW_FILL)}},
        '{dssm_pkg::CMD_PUSH, dssm_pkg::SEL_HIGH, 32'h87654321, 16'd1, 1'b1,
          '{dssm_pkg::STAT_OVERFLOW, 32'h0, CW'(LOW_FILL), CW'(dssm_pkg::DEPTH - LOW_FILL)}},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_HIGH, 32'h0,
          16'(dssm_pkg::DEPTH - LOW_FILL), 1'b0, '0},
        '{dssm_pkg::CMD_POP,  dssm_pkg::SEL_LOW,  32'h0,        16'(LOW_FILL), 1'b0, '0}
    };

    dual_stack_shared_memory_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_stack_select (i_stack_select),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_pop_value    (o_pop_value),
        .o_low_count    (o_low_count),
        .o_high_count   (o_high_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Applies one push or pop to the local copy of both stacks.
    function automatic t_result predict_stack_op(logic cmd, logic sel,
                                                 logic [dssm_pkg::DATA_W-1:0] value);
        t_result r;
        r.status    = dssm_pkg::STAT_OK;
        r.pop_value = '0;
        if (cmd == dssm_pkg::CMD_PUSH) begin
            if (low_depth + high_depth < dssm_pkg::DEPTH) begin
                if (sel == dssm_pkg::SEL_LOW) begin
                    stack_mem[low_depth] = value;
                    low_depth++;
                end else begin
                    stack_mem[dssm_pkg::DEPTH - 1 - high_depth] = value;
                    high_depth++;
                end
            end else begin
                r.status = dssm_pkg::STAT_OVERFLOW;
            end
        end else if (sel == dssm_pkg::SEL_LOW) begin
            if (low_depth > 0) begin
                low_depth--;
                r.pop_value = stack_mem[low_depth];
            end else begin
                r.status    = dssm_pkg::STAT_UNDERFLOW;
                r.pop_value = '1;
            end
        end else begin
            if (high_depth > 0) begin
                r.pop_value = stack_mem[dssm_pkg::DEPTH - high_depth];
                high_depth--;
            end else begin
                r.status    = dssm_pkg::STAT_UNDERFLOW;
                r.pop_value = '1;
            end
        end
        r.low_count  = CW'(low_depth);
        r.high_count = CW'(high_depth);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result model_res;
        t_result exp_res;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                model_res = predict_stack_op(i_command, i_stack_select, i_push_value);
                pending_results.push_back(beat_typed ? beat_result : model_res);
                cmd_count++;
                if (i_command == dssm_pkg::CMD_POP && model_res.status == dssm_pkg::STAT_OK)
                    data_pop_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d pop_value %h",
                           o_status, o_pop_value);
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (exp_res.status == dssm_pkg::STAT_OVERFLOW) overflow_count++;
                    if (exp_res.status == dssm_pkg::STAT_UNDERFLOW) underflow_count++;
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                        fail_count++;
                    end
                    if (o_pop_value !== exp_res.pop_value) begin
                        $error("pop_value: expected %h, actual %h",
                               exp_res.pop_value, o_pop_value);
                        fail_count++;
                    end
                    if (o_low_count !== exp_res.low_count) begin
                        $error("low_count: expected %0d, actual %0d",
                               exp_res.low_count, o_low_count);
                        fail_count++;
                    end
                    if (o_high_count !== exp_res.high_count) begin
                        $error("high_count: expected %0d, actual %0d",
                               exp_res.high_count, o_high_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver side: stall in bursts while enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Drives one command beat and returns at the edge where it is taken.
    task automatic send_cmd(logic cmd, logic sel, logic [dssm_pkg::DATA_W-1:0] value,
                            logic typed, t_result res);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_stack_select <= sel;
        i_push_value   <= value;
        beat_typed     <= typed;
        beat_result    <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        t_row        row;
        int          rand_done;
        int          phase;
        int          push_pct;
        int          low_pct;
        int          span;
        logic        cmd;
        logic        sel;
        logic [31:0] value;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on  <= 1'b1;
        stall_on <= 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED[r];
            for (int k = 0; k < row.reps; k++)
                send_cmd(row.cmd, row.sel, row.value + k, row.typed, row.res);
        end

        // Random phases lean toward filling, draining or churning so that both
        // the full memory and the empty stacks are met again and again.
        rand_done = 0;
        phase = 0;
        while (rand_done < RAND_ITEMS) begin
            case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 3))
                0: push_pct = 88;
                1: push_pct = 12;
                2: push_pct = 50;
                default: push_pct = $urandom_range(0, 100);
            endcase
            case ($urandom_range(0, 3))
                0: low_pct = 10;
                1: low_pct = 90;
                default: low_pct = 50;
            endcase
            span = $urandom_range(60, 220);
            idle_on  <= (rand_done < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            stall_on <= (rand_done < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < span && rand_done < RAND_ITEMS; k++) begin
                if (rand_done == RAND_ITEMS - QUIET_TAIL) begin
                    idle_on  <= 1'b0;
                    stall_on <= 1'b0;
                end
                cmd = ($urandom_range(1, 100) <= push_pct) ? dssm_pkg::CMD_PUSH
                                                            : dssm_pkg::CMD_POP;
                sel = ($urandom_range(1, 100) <= low_pct) ? dssm_pkg::SEL_LOW
                                                           : dssm_pkg::SEL_HIGH;
                case ($urandom_range(0, 15))
                    0: value = 32'h00000000;
                    1: value = 32'hFFFFFFFF;
                    2: value = 32'h7FFFFFFF;
                    3: value = 32'h80000000;
                    default: value = $urandom;
                endcase
                send_cmd(cmd, sel, value, 1'b0, '0);
                rand_done++;
            end
            phase++;
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d push/pop commands, %0d results checked; %0d overflows, %0d underflows.",
                 cmd_count, result_count, overflow_count, underflow_count);
        $display("%0d pops returned stored words across both stacks.", data_pop_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
